### rtl/core/iejq_pkg.sv
// package for the input event jitter queue
// constants, codes and the entry type used by the core
package iejq_pkg;

   localparam int QueueDepth = 64;
   localparam int IdxW = $clog2(QueueDepth);
   localparam int CntW = IdxW + 1;
   localparam int RescueKeys = 4;
   localparam int MaxResults = 64;
   localparam int EntryW = 32 + 6 + 16 + 16 + 32;

   localparam logic [15:0] TY_SYN = 16'd0;
   localparam logic [15:0] TY_KEY = 16'd1;
   localparam logic [15:0] TY_REL = 16'd2;
   localparam logic [15:0] TY_ABS = 16'd3;

   localparam logic [1:0] ST_QUEUED = 2'd0;
   localparam logic [1:0] ST_MERGED = 2'd1;
   localparam logic [1:0] ST_DUP    = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam logic [2:0] REG_MAX_DELAY = 3'd0;
   localparam logic [2:0] REG_RESC_EN   = 3'd1;
   localparam logic [2:0] REG_RESC_CNT  = 3'd2;
   localparam logic [2:0] REG_KEY0      = 3'd3;

   typedef struct packed {
      logic [31:0] etime;
      logic [5:0]  device;
      logic [15:0] etype;
      logic [15:0] code;
      logic [31:0] value;
   } entry_type;

   function automatic logic in_merge_set(input logic [15:0] ty, input logic [15:0] cd);
      if (ty == TY_REL)
         return cd == 16'd0 || cd == 16'd1 || cd == 16'd6 || cd == 16'd8 ||
                cd == 16'd11 || cd == 16'd12;
      return cd == 16'd0 || cd == 16'd1;
   endfunction

   function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] s;
      s = a + b;
      if (a[31] == b[31] && s[31] != a[31])
         return a[31] ? 32'h8000_0000 : 32'h7fff_ffff;
      return s;
   endfunction

endpackage

### rtl/core/iejq_ram.sv
// generic single port ram with registered read
// no dependencies
module iejq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

### rtl/core/input_event_jitter_queue.sv
// input event jitter queue top level: sequencer around the entry ram
// depends on iejq_pkg and iejq_ram
//
// usage:
//  req channel carries one word per input: tuser is cmd (0 event, 1 ms tick),
//  tdata holds device, evt_type, event_code, event_value, random_word.
//  an event gives one rsp word with tuser kind 1 and status/rescue_hit in
//  tdata. a tick advances the ms clock and releases every due entry at the
//  head as kind 0 words, the final one with tlast; nothing due gives nothing.
//  csr port writes the delay cap, rescue_enable, rescue_count, rescue keys.
// timing:
//  the queue lives in one single port ram with registered read; every
//  read is issued, waited for and then used. a motion event may walk back
//  over up to 64 entries before its rsp word; a tick releases up to 64
//  entries. one input is handled at a time; req_tready is low meanwhile.
// reset: synchronous, clears clock, head, fill count and held keys; the ram
//  is not cleared, only data from filled slots is ever used.
// stall: an output register holds each rsp word until taken; a released word
//  waits in a staging register until the next head entry is checked, so its
//  tlast is known before it goes out; the sequencer waits on the output.
module input_event_jitter_queue (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // device[5:0], evt_type[21:6], event_code[37:22], event_value[69:38],
   // random_word[85:70], zero fill
   input  logic [87:0]   req_tdata,
   // cmd
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_device[5:0], out_type[21:6], out_code[37:22], out_value[69:38],
   // status[71:70], rescue_hit[72], zero fill
   output logic [79:0]   rsp_tdata,
   // kind
   output logic          rsp_tuser,
   output logic          rsp_tlast,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata
);
   localparam int IW = iejq_pkg::IdxW;
   localparam int CW = iejq_pkg::CntW;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b0_0000_0001,
      S_EVT   = 9'b0_0000_0010,
      S_WREQ  = 9'b0_0000_0100,
      S_WCHK  = 9'b0_0000_1000,
      S_TREQ  = 9'b0_0001_0000,
      S_TCHK  = 9'b0_0010_0000,
      S_MUL   = 9'b0_0100_0000,
      S_SEND  = 9'b0_1000_0000,
      S_TLAST = 9'b1_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] delay_cap_ff;
   logic        resc_en_ff;
   logic [2:0]  resc_cnt_ff;
   logic [9:0]  resc_key_ff [iejq_pkg::RescueKeys];

   // queue control
   logic [31:0] now_ff, now_in;
   logic [31:0] last_rel_ff, last_rel_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [iejq_pkg::RescueKeys-1:0] held_ff, held_in;

   // captured input
   logic [5:0]  dev_ff;
   logic [15:0] typ_ff, code_ff, draw_ff;
   logic [31:0] val_ff;
   logic [15:0] lb_ff, lb_in;
   logic        hit_ff, hit_in;
   logic        xs_ff, xs_in, ys_ff, ys_in;
   logic [CW-1:0] walk_ff, walk_in;
   logic [6:0]  nrel_ff, nrel_in;
   logic [31:0] prod_ff, prod_in;

   // staged word: status of an event or the last released entry
   logic [79:0] pw_ff, pw_in;

   // output register
   logic        ov_ff, ov_in;
   logic [79:0] od_ff, od_in;
   logic        ok_ff, ok_in, ol_ff, ol_in;

   // ram port
   logic          we;
   logic [IW-1:0] addr;
   iejq_pkg::entry_type wentry, rentry;

   iejq_ram #(.Width(iejq_pkg::EntryW), .Depth(iejq_pkg::QueueDepth)) u_ram (
      .clock (clock),
      .we    (we),
      .addr  (addr),
      .wdata (wentry),
      .rdata (rentry)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = ok_ff;
   assign rsp_tlast  = ol_ff;

   logic [5:0]  q_dev;
   logic [15:0] q_typ, q_code, q_draw;
   logic [31:0] q_val;
   assign q_dev  = req_tdata[5:0];
   assign q_typ  = req_tdata[21:6];
   assign q_code = req_tdata[37:22];
   assign q_val  = req_tdata[69:38];
   assign q_draw = req_tdata[85:70];

   // lower bound from last scheduled release
   logic [31:0] gap;
   assign gap = last_rel_ff - now_ff;

   // rescue tracking on accept
   logic [2:0] rcnt;
   assign rcnt = (resc_cnt_ff > 3'(iejq_pkg::RescueKeys)) ? 3'(iejq_pkg::RescueKeys)
                                                          : resc_cnt_ff;

   logic          out_free;
   assign out_free = !ov_ff || rsp_tready;

   logic [IW-1:0] tail_slot;
   logic [IW-1:0] walk_slot;
   assign tail_slot = head_ff + fill_ff[IW-1:0];
   assign walk_slot = head_ff + walk_ff[IW-1:0] - IW'(1);

   logic [16:0] span;
   assign span = {1'b0, delay_cap_ff} - {1'b0, lb_ff} + 17'd1;

   function automatic logic [79:0] status_word(input logic [1:0] st, input logic h);
      return {7'd0, h, st, 70'd0};
   endfunction

   always_comb begin
      state_in = state_ff;
      now_in = now_ff; last_rel_in = last_rel_ff; head_in = head_ff; fill_in = fill_ff;
      held_in = held_ff; lb_in = lb_ff; hit_in = hit_ff; xs_in = xs_ff; ys_in = ys_ff;
      walk_in = walk_ff; nrel_in = nrel_ff; prod_in = prod_ff; pw_in = pw_ff;
      ov_in = ov_ff && !rsp_tready; od_in = od_ff; ok_in = ok_ff; ol_in = ol_ff;
      we = 1'b0; addr = tail_slot;
      wentry.etime = now_ff + 32'(lb_ff);
      wentry.device = dev_ff; wentry.etype = typ_ff; wentry.code = code_ff;
      wentry.value = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser) begin
                  now_in = now_ff + 32'd1;
                  nrel_in = '0;
                  state_in = S_TREQ;
               end else begin
                  logic all;
                  all = 1'b1;
                  hit_in = 1'b0;
                  if (resc_en_ff && q_typ == iejq_pkg::TY_KEY) begin
                     for (int k = 0; k < iejq_pkg::RescueKeys; k++) begin
                        if (3'(k) < rcnt) begin
                           if (q_code == {6'd0, resc_key_ff[k]})
                              held_in[k] = (q_val != 32'd0);
                           if (!held_in[k]) all = 1'b0;
                        end
                     end
                     hit_in = all;
                  end
                  if (gap[31]) lb_in = '0;
                  else if (gap > {16'd0, delay_cap_ff}) lb_in = delay_cap_ff;
                  else lb_in = gap[15:0];
                  xs_in = 1'b0; ys_in = 1'b0;
                  walk_in = fill_ff;
                  addr = head_ff + fill_ff[IW-1:0] - IW'(1);
                  state_in = S_EVT;
               end
            end
         end
         S_EVT: begin
            // the read of the newest entry issued in idle is now on rentry
            if (typ_ff == iejq_pkg::TY_SYN) begin
               if (fill_ff != '0 && rentry.etype == iejq_pkg::TY_SYN) begin
                  pw_in = status_word(iejq_pkg::ST_DUP, hit_ff); state_in = S_SEND;
               end else begin
                  state_in = S_MUL; prod_in = '0;
               end
            end else if ((typ_ff == iejq_pkg::TY_REL || typ_ff == iejq_pkg::TY_ABS) &&
                         iejq_pkg::in_merge_set(typ_ff, code_ff)) begin
               addr = walk_slot;
               state_in = S_WCHK;
               if (walk_ff == '0) state_in = S_MUL;
               prod_in = {16'd0, draw_ff} * {15'd0, span};
               if (walk_ff == '0 && (lb_ff >= delay_cap_ff)) prod_in = '0;
            end else begin
               prod_in = {16'd0, draw_ff} * {15'd0, span};
               state_in = S_MUL;
            end
         end
         S_WREQ: begin
            addr = walk_slot;
            state_in = S_WCHK;
         end
         S_WCHK: begin
            addr = walk_slot;
            if (rentry.etype != typ_ff && rentry.etype != iejq_pkg::TY_SYN) begin
               state_in = S_MUL;
            end else if (rentry.etype == typ_ff) begin
               if (rentry.code == 16'd0) xs_in = 1'b1;
               else if (rentry.code == 16'd1) ys_in = 1'b1;
               if (!iejq_pkg::in_merge_set(typ_ff, rentry.code)) begin
                  state_in = S_MUL;
               end else if (rentry.code == code_ff) begin
                  we = 1'b1;
                  wentry = rentry;
                  wentry.value = (typ_ff == iejq_pkg::TY_REL)
                                 ? iejq_pkg::sat_add32(rentry.value, val_ff) : val_ff;
                  pw_in = status_word(iejq_pkg::ST_MERGED, hit_ff);
                  state_in = S_SEND;
               end else begin
                  walk_in = walk_ff - CW'(1);
                  state_in = (walk_ff == CW'(1)) ? S_MUL : S_WREQ;
               end
            end else begin
               walk_in = walk_ff - CW'(1);
               state_in = (walk_ff == CW'(1)) ? S_MUL : S_WREQ;
            end
         end
         S_MUL: begin
            // enqueue with delay lb, the cap, or lb + (draw*span)>>16; when full, status only
            logic [15:0] dly;
            logic        use_lb;
            use_lb = typ_ff == iejq_pkg::TY_SYN ||
                     ((typ_ff == iejq_pkg::TY_REL || typ_ff == iejq_pkg::TY_ABS) &&
                      iejq_pkg::in_merge_set(typ_ff, code_ff) &&
                      ((code_ff == 16'd0 && ys_ff) || (code_ff == 16'd1 && xs_ff)));
            if (use_lb) dly = lb_ff;
            else if (lb_ff >= delay_cap_ff) dly = delay_cap_ff;
            else dly = lb_ff + prod_ff[31:16];
            if (fill_ff[CW-1]) begin
               pw_in = status_word(iejq_pkg::ST_FULL, hit_ff);
            end else begin
               we = 1'b1;
               addr = tail_slot;
               wentry.etime = now_ff + 32'(dly);
               last_rel_in = now_ff + 32'(dly);
               fill_in = fill_ff + CW'(1);
               pw_in = status_word(iejq_pkg::ST_QUEUED, hit_ff);
            end
            state_in = S_SEND;
         end
         S_SEND: begin
            if (out_free) begin
               ov_in = 1'b1; ok_in = 1'b1; ol_in = 1'b1; od_in = pw_ff;
               state_in = S_IDLE;
            end
         end
         S_TREQ: begin
            addr = head_ff;
            if (fill_ff == '0 || nrel_ff == 7'(iejq_pkg::MaxResults)) begin
               state_in = (nrel_ff != '0) ? S_TLAST : S_IDLE;
            end else begin
               state_in = S_TCHK;
            end
         end
         S_TCHK: begin
            logic [31:0] df;
            df = now_ff - rentry.etime;
            addr = head_ff;
            if (df[31]) begin
               state_in = (nrel_ff != '0) ? S_TLAST : S_IDLE;
            end else if (nrel_ff == '0 || out_free) begin
               // another entry is due, so the staged one is not the last
               if (nrel_ff != '0) begin
                  ov_in = 1'b1; ok_in = 1'b0; ol_in = 1'b0; od_in = pw_ff;
               end
               pw_in = {10'd0, rentry.value, rentry.code, rentry.etype, rentry.device};
               head_in = head_ff + IW'(1);
               fill_in = fill_ff - CW'(1);
               nrel_in = nrel_ff + 7'd1;
               state_in = S_TREQ;
            end
         end
         S_TLAST: begin
            if (out_free) begin
               ov_in = 1'b1; ok_in = 1'b0; ol_in = 1'b1; od_in = pw_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         now_ff <= '0; last_rel_ff <= '0; head_ff <= '0; fill_ff <= '0; held_ff <= '0;
         ov_ff <= 1'b0;
         delay_cap_ff <= 16'd100; resc_en_ff <= 1'b1; resc_cnt_ff <= 3'd3;
         resc_key_ff[0] <= 10'd42; resc_key_ff[1] <= 10'd54;
         resc_key_ff[2] <= 10'd1;  resc_key_ff[3] <= 10'd0;
      end else begin
         state_ff <= state_in;
         now_ff <= now_in; last_rel_ff <= last_rel_in; head_ff <= head_in;
         fill_ff <= fill_in; held_ff <= held_in;
         ov_ff <= ov_in;
         if (csr_we) begin
            unique case (csr_index)
               iejq_pkg::REG_MAX_DELAY: delay_cap_ff <= csr_wdata;
               iejq_pkg::REG_RESC_EN:   resc_en_ff <= csr_wdata[0];
               iejq_pkg::REG_RESC_CNT:  resc_cnt_ff <= csr_wdata[2:0];
               default: begin
                  if (csr_index >= iejq_pkg::REG_KEY0 &&
                      csr_index < iejq_pkg::REG_KEY0 + 3'(iejq_pkg::RescueKeys))
                     resc_key_ff[2'(csr_index - iejq_pkg::REG_KEY0)] <= csr_wdata[9:0];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         dev_ff <= q_dev; typ_ff <= q_typ; code_ff <= q_code;
         val_ff <= q_val; draw_ff <= q_draw;
      end
      lb_ff <= lb_in; hit_ff <= hit_in; xs_ff <= xs_in; ys_ff <= ys_in;
      walk_ff <= walk_in; nrel_ff <= nrel_in; prod_ff <= prod_in; pw_ff <= pw_in;
      od_ff <= od_in; ok_ff <= ok_in; ol_ff <= ol_in;
   end
endmodule

### rtl/core/iejq_checker.sv
// port level checker for the input event jitter queue, bound to the top
// depends on input_event_jitter_queue
module iejq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata[69:0] == 70'd0)
      else $error("status word malformed");

   a_release_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[72:70] == 3'd0)
      else $error("released word carries status");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted while busy");

   a_reset: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp valid out of reset");
endmodule

bind input_event_jitter_queue iejq_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);
